FILE: rtl/spfd_pkg.sv
// ----------------------------------------------------------------------------
// spfd_pkg
// Shared types and constants of the save file directory.
// ----------------------------------------------------------------------------
package spfd_pkg;

   localparam int SLOTS        = 16;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int BUDGET_BYTES = 123 * 256;
   localparam int WINDOW_BYTES = 32768;
   localparam int WIN_W        = $clog2(WINDOW_BYTES);
   localparam int ADDR_W       = SLOT_W + WIN_W;
   localparam int SIZE_W       = 15;
   localparam int COUNT_W      = $clog2(SLOTS + 1);

   localparam logic [3:0] FUNC_CHECK    = 4'd0;
   localparam logic [3:0] FUNC_FREE     = 4'd1;
   localparam logic [3:0] FUNC_COUNT    = 4'd2;
   localparam logic [3:0] FUNC_ALLOCATE = 4'd3;
   localparam logic [3:0] FUNC_DELETE   = 4'd4;
   localparam logic [3:0] FUNC_FIND     = 4'd5;
   localparam logic [3:0] FUNC_STATE    = 4'd6;
   localparam logic [3:0] FUNC_READ     = 4'd7;
   localparam logic [3:0] FUNC_WRITE    = 4'd8;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NOPACK   = 3'd1;
   localparam logic [2:0] STATUS_INVALID  = 3'd2;
   localparam logic [2:0] STATUS_DATAFULL = 3'd3;
   localparam logic [2:0] STATUS_DIRFULL  = 3'd4;
   localparam logic [2:0] STATUS_EXISTS   = 3'd5;

   typedef struct packed {
      logic [3:0]  func;
      logic        pak_present;
      logic [15:0] maker_id;
      logic [31:0] title_id;
      logic [63:0] name_high;
      logic [63:0] name_low;
      logic [31:0] extension;
      logic [14:0] alloc_len;
      logic [3:0]  file_number;
      logic [14:0] offset;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_found;
      logic [14:0] free_bytes;
      logic [4:0]  used_count;
      logic [14:0] state_size;
      logic [31:0] state_game;
      logic [15:0] state_company;
      logic [31:0] state_extension;
      logic [63:0] state_name_high;
      logic [63:0] state_name_low;
      logic [7:0]  read_byte;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_CLEAR,
      ST_ACCESS,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/spfd_data.sv
// ----------------------------------------------------------------------------
// spfd_data
// File data store: one window per slot, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module spfd_data
   import spfd_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [SLOTS*WINDOW_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/save_pak_file_directory.sv
// Sequence: check, free, count, delete and find walk all slots, decide, then strobe;
//   allocate also zeroes the new file's bytes in its window before the strobe.
// State and write: access, then strobe; read: access, a wait on the registered data store,
//   then strobe. Bad operation or missing pack: straight to the strobe.
// One request at a time; busy stays high until the result strobe is due.
// The slot walk goes one slot per cycle through the shared adder and key compare.
//   Reset empties the directory at once; the data store needs no clearing.
// ----------------------------------------------------------------------------
// save_pak_file_directory
// Sixteen-slot file directory with shared byte budget and per-slot data window.
// ----------------------------------------------------------------------------
module save_pak_file_directory
   import spfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SIZE_W:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] found_slot_ff, found_slot_in;
   logic              free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic [WIN_W-1:0]  cnt_ff, cnt_in;

   logic              used_ff [SLOTS];
   logic [15:0]       company_ff [SLOTS];
   logic [31:0]       game_ff [SLOTS];
   logic [63:0]       name_high_ff [SLOTS];
   logic [63:0]       name_low_ff [SLOTS];
   logic [31:0]       extension_ff [SLOTS];
   logic [SIZE_W-1:0] size_ff [SLOTS];

   logic              alloc_we, delete_we;
   mem_req_type       mem_req;
   logic [7:0]        mem_rd_data;
   logic              cur_used, cur_match;
   logic [SIZE_W:0]   need;

   spfd_data u_data (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign cur_used  = used_ff[idx_ff];
   assign cur_match = cur_used && company_ff[idx_ff] == req_ff.maker_id &&
                      game_ff[idx_ff] == req_ff.title_id &&
                      name_high_ff[idx_ff] == req_ff.name_high &&
                      name_low_ff[idx_ff] == req_ff.name_low &&
                      extension_ff[idx_ff] == req_ff.extension;
   assign need = sum_ff + {1'b0, req_ff.alloc_len};

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      free_ok_in    = free_ok_ff;
      free_slot_in  = free_slot_ff;
      cnt_in        = cnt_ff;
      alloc_we      = 1'b0;
      delete_we     = 1'b0;
      mem_req       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               rsp_in     = '0;
               idx_in     = '0;
               sum_in     = '0;
               count_in   = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               cnt_in     = '0;
               if (req_data.func > FUNC_WRITE) begin
                  rsp_in.status = STATUS_INVALID;
                  state_in      = ST_DONE;
               end else if (!req_data.pak_present) begin
                  rsp_in.status = STATUS_NOPACK;
                  state_in      = ST_DONE;
               end else if (req_data.func inside {FUNC_STATE, FUNC_READ, FUNC_WRITE}) begin
                  idx_in   = req_data.file_number[SLOT_W-1:0];
                  state_in = ST_ACCESS;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one slot a cycle through the shared adder and key compare
            if (cur_used) begin
               sum_in   = sum_ff + {1'b0, size_ff[idx_ff]};
               count_in = count_ff + 1'b1;
            end
            if (cur_match && !found_ff) begin
               found_in      = 1'b1;
               found_slot_in = idx_ff;
            end
            if (!cur_used && !free_ok_ff) begin
               free_ok_in   = 1'b1;
               free_slot_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            case (req_ff.func)
               FUNC_FREE:  rsp_in.free_bytes = SIZE_W'(BUDGET_BYTES - int'(sum_ff));
               FUNC_COUNT: rsp_in.used_count = count_ff;
               FUNC_ALLOCATE: begin
                  if (req_ff.alloc_len == '0 || req_ff.alloc_len > SIZE_W'(BUDGET_BYTES)) begin
                     rsp_in.status = STATUS_INVALID;
                  end else if (found_ff) begin
                     rsp_in.status = STATUS_EXISTS;
                  end else if (need > (SIZE_W+1)'(BUDGET_BYTES)) begin
                     rsp_in.status = STATUS_DATAFULL;
                  end else if (!free_ok_ff) begin
                     rsp_in.status = STATUS_DIRFULL;
                  end else begin
                     alloc_we          = 1'b1;
                     rsp_in.slot_found = free_slot_ff;
                     state_in          = ST_CLEAR;
                  end
               end
               FUNC_DELETE: begin
                  if (found_ff) begin
                     delete_we = 1'b1;
                  end else begin
                     rsp_in.status = STATUS_INVALID;
                  end
               end
               FUNC_FIND: begin
                  if (found_ff) begin
                     rsp_in.slot_found = found_slot_ff;
                  end else begin
                     rsp_in.status = STATUS_INVALID;
                  end
               end
               default: ;
            endcase
         end
         ST_CLEAR: begin
            // zero the new file's bytes in its window, one byte a cycle
            mem_req.wr_en = 1'b1;
            mem_req.addr  = {free_slot_ff, cnt_ff};
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == WIN_W'(req_ff.alloc_len - 1'b1)) begin
               state_in = ST_DONE;
            end
         end
         ST_ACCESS: begin
            state_in = ST_DONE;
            if (!cur_used) begin
               rsp_in.status = STATUS_INVALID;
            end else if (req_ff.func == FUNC_STATE) begin
               rsp_in.state_size      = size_ff[idx_ff];
               rsp_in.state_game      = game_ff[idx_ff];
               rsp_in.state_company   = company_ff[idx_ff];
               rsp_in.state_extension = extension_ff[idx_ff];
               rsp_in.state_name_high = name_high_ff[idx_ff];
               rsp_in.state_name_low  = name_low_ff[idx_ff];
            end else if (req_ff.offset >= size_ff[idx_ff]) begin
               rsp_in.status = STATUS_INVALID;
            end else begin
               mem_req.addr  = {idx_ff, req_ff.offset[WIN_W-1:0]};
               mem_req.wdata = req_ff.write_byte;
               if (req_ff.func == FUNC_READ) begin
                  mem_req.rd_en = 1'b1;
                  state_in      = ST_READ_WAIT;
               end else begin
                  mem_req.wr_en = 1'b1;
               end
            end
         end
         ST_READ_WAIT: begin
            rsp_in.read_byte = mem_rd_data;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      idx_ff        <= idx_in;
      sum_ff        <= sum_in;
      count_ff      <= count_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      free_ok_ff    <= free_ok_in;
      free_slot_ff  <= free_slot_in;
      cnt_ff        <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            used_ff[s] <= 1'b0;
         end
      end else if (alloc_we) begin
         used_ff[free_slot_ff] <= 1'b1;
      end else if (delete_we) begin
         used_ff[found_slot_ff] <= 1'b0;
      end
   end

   // key fields of a free slot are never looked at, so delete leaves them
   always_ff @(posedge clock) begin
      if (alloc_we) begin
         company_ff[free_slot_ff]   <= req_ff.maker_id;
         game_ff[free_slot_ff]      <= req_ff.title_id;
         name_high_ff[free_slot_ff] <= req_ff.name_high;
         name_low_ff[free_slot_ff]  <= req_ff.name_low;
         extension_ff[free_slot_ff] <= req_ff.extension;
         size_ff[free_slot_ff]      <= req_ff.alloc_len;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/spfd_checker.sv
// ----------------------------------------------------------------------------
// spfd_checker
// Port-level checks of the save file directory, bound to the top level.
// ----------------------------------------------------------------------------
module spfd_checker
   import spfd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or result strobe right after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.slot_found == '0 && rsp_data.free_bytes == '0 &&
         rsp_data.used_count == '0 && rsp_data.read_byte == '0 &&
         rsp_data.state_size == '0)
      else $error("error result carries nonzero fields");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without work in progress");

endmodule

bind save_pak_file_directory spfd_checker u_spfd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
